// ===== sv/frta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package frta_pkg;

   localparam int ADDR_BITS = 64;

   localparam logic [2:0] CMD_APPEND  = 3'd0;
   localparam logic [2:0] CMD_DEFRAG  = 3'd1;
   localparam logic [2:0] CMD_POP_EX  = 3'd2;
   localparam logic [2:0] CMD_POP_UPTO = 3'd3;
   localparam logic [2:0] CMD_READ    = 3'd4;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_NONE  = 3'd1;
   localparam logic [2:0] ST_ALIGN = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_INDEX = 3'd4;

   typedef struct packed {
      logic [ADDR_BITS-1:0] base;
      logic [ADDR_BITS-1:0] size;
   } entry_type;

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_SORT_RD   = 10'b00_0000_0010,
      S_SORT_CMP  = 10'b00_0000_0100,
      S_SORT_END  = 10'b00_0000_1000,
      S_MERGE_RD  = 10'b00_0001_0000,
      S_MERGE_CMP = 10'b00_0010_0000,
      S_MERGE_END = 10'b00_0100_0000,
      S_POP_RD    = 10'b00_1000_0000,
      S_POP_CMP   = 10'b01_0000_0000,
      S_DONE      = 10'b10_0000_0000
   } state_type;

endpackage

`default_nettype wire

// ===== sv/free_range_table_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake           | payload
// req_    | in        | req_valid/req_stall | command, entry_index, range_start,
//         |           |                     | range_length, req_size
// rsp_    | out       | rsp_valid/rsp_stall | status, granted_addr, granted_size,
//         |           |                     | entry_total
//
// Pops scan the table entry by entry.
// Defragment: stable bubble passes over the table, which has one read and one write port,
// up to N passes, then one merge scan.
// Reset empties the table at once; no clearing pass.
// A finished beat waits in the output register; the next beat is taken meanwhile.

module free_range_table_allocator
   import frta_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int PAGE_BITS   = 12
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  [2:0]           req_command,
   input  wire  [5:0]           req_entry_index,
   input  wire  [ADDR_BITS-1:0] req_range_start,
   input  wire  [ADDR_BITS-1:0] req_range_length,
   input  wire  [ADDR_BITS-1:0] req_size,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [ADDR_BITS-1:0] rsp_granted_addr,
   output logic [ADDR_BITS-1:0] rsp_granted_size,
   output logic [6:0]           rsp_entry_total
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (CW > 6) ? CW : 6;
   localparam int OW = (CW > 7) ? CW : 7;
   localparam logic [ADDR_BITS-1:0] PAGE_MASK = (ADDR_BITS'(1) << PAGE_BITS) - ADDR_BITS'(1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] w_ff, w_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0] want_ff, want_in;
   entry_type     carry_ff, carry_in;
   logic          swap_ff, swap_in;
   logic          have_ff, have_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   entry_type     best_ff, best_in;
   logic [2:0]           res_status_ff, res_status_in;
   logic [ADDR_BITS-1:0] res_addr_ff, res_addr_in;
   logic [ADDR_BITS-1:0] res_size_ff, res_size_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic [ADDR_BITS-1:0] rsp_size_ff, rsp_size_in;
   logic [6:0]           rsp_total_ff, rsp_total_in;

   logic          last;
   logic [ADDR_BITS-1:0] cur_end, nxt_end;
   logic [IW-1:0] idx_w;
   logic [OW-1:0] cnt_w;

   assign last    = (CW'(i_ff) == count_ff - CW'(1));
   assign cur_end = carry_ff.base + carry_ff.size;
   assign nxt_end = rd_data_ff.base + rd_data_ff.size;
   assign idx_w   = IW'(req_entry_index);
   assign cnt_w   = OW'(count_ff);

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_addr = rsp_addr_ff;
   assign rsp_granted_size = rsp_size_ff;
   assign rsp_entry_total  = rsp_total_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      w_in          = w_ff;
      cmd_in        = cmd_ff;
      want_in       = want_ff;
      carry_in      = carry_ff;
      swap_in       = swap_ff;
      have_in       = have_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_total_in  = rsp_total_ff;
      rd_addr       = i_ff;
      wr_en         = 1'b0;
      wr_addr       = i_ff;
      wr_data       = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               want_in       = req_size;
               res_status_in = ST_OK;
               res_addr_in   = '0;
               res_size_in   = '0;
               i_in          = '0;
               w_in          = '0;
               swap_in       = 1'b0;
               have_in       = 1'b0;
               state_in      = S_DONE;
               case (req_command)
                  CMD_APPEND: begin
                     if (count_ff < DEPTH_C) begin
                        wr_en        = 1'b1;
                        wr_addr      = AW'(count_ff);
                        wr_data.base = req_range_start;
                        wr_data.size = req_range_length;
                        count_in     = count_ff + CW'(1);
                     end else begin
                        res_status_in = ST_FULL;
                     end
                  end
                  CMD_DEFRAG: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_NONE;
                     end else if (count_ff == CW'(1)) begin
                        state_in = S_MERGE_RD;
                     end else begin
                        state_in = S_SORT_RD;
                     end
                  end
                  CMD_POP_EX, CMD_POP_UPTO: begin
                     if ((req_size & PAGE_MASK) != '0) begin
                        res_status_in = ST_ALIGN;
                     end else if (count_ff == '0) begin
                        res_status_in = ST_NONE;
                     end else begin
                        state_in = S_POP_RD;
                     end
                  end
                  CMD_READ: begin
                     if (idx_w < IW'(count_ff)) begin
                        rd_addr  = AW'(idx_w);
                        state_in = S_POP_CMP;
                     end else begin
                        res_status_in = ST_INDEX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SORT_RD: begin
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            if (i_ff == '0) begin
               carry_in = rd_data_ff;
            end else begin
               wr_en   = 1'b1;
               wr_addr = i_ff - AW'(1);
               if (carry_ff.base > rd_data_ff.base) begin
                  wr_data = rd_data_ff;
                  swap_in = 1'b1;
               end else begin
                  wr_data  = carry_ff;
                  carry_in = rd_data_ff;
               end
            end
            if (last) begin
               state_in = S_SORT_END;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_SORT_RD;
            end
         end
         S_SORT_END: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = carry_ff;
            i_in    = '0;
            swap_in = 1'b0;
            state_in = swap_ff ? S_SORT_RD : S_MERGE_RD;
         end
         S_MERGE_RD: begin
            state_in = S_MERGE_CMP;
         end
         S_MERGE_CMP: begin
            if (rd_data_ff.size != '0) begin
               if (!have_ff) begin
                  carry_in = rd_data_ff;
                  have_in  = 1'b1;
               end else if (cur_end >= rd_data_ff.base) begin
                  if (nxt_end > cur_end) begin
                     carry_in.size = nxt_end - carry_ff.base;
                  end
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = w_ff;
                  wr_data  = carry_ff;
                  w_in     = w_ff + AW'(1);
                  carry_in = rd_data_ff;
               end
            end
            if (last) begin
               state_in = S_MERGE_END;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_MERGE_RD;
            end
         end
         S_MERGE_END: begin
            if (have_ff) begin
               wr_en    = 1'b1;
               wr_addr  = w_ff;
               wr_data  = carry_ff;
               count_in = CW'(w_ff) + CW'(1);
            end else begin
               count_in = '0;
            end
            state_in = S_DONE;
         end
         S_POP_RD: begin
            state_in = S_POP_CMP;
         end
         S_POP_CMP: begin
            if (cmd_ff == CMD_READ) begin
               res_addr_in = rd_data_ff.base;
               res_size_in = rd_data_ff.size;
               state_in    = S_DONE;
            end else if (rd_data_ff.size >= want_ff) begin
               res_addr_in  = rd_data_ff.base;
               res_size_in  = want_ff;
               wr_en        = 1'b1;
               wr_data.base = rd_data_ff.base + want_ff;
               wr_data.size = rd_data_ff.size - want_ff;
               state_in     = S_DONE;
            end else begin
               if (i_ff == '0 || rd_data_ff.size > best_ff.size) begin
                  best_in     = rd_data_ff;
                  best_idx_in = i_ff;
               end
               if (last) begin
                  state_in = S_DONE;
                  if (cmd_ff == CMD_POP_EX) begin
                     res_status_in = ST_NONE;
                  end else begin
                     res_addr_in  = best_in.base;
                     res_size_in  = best_in.size;
                     wr_en        = 1'b1;
                     wr_addr      = best_idx_in;
                     wr_data.base = best_in.base;
                     wr_data.size = '0;
                  end
               end else begin
                  i_in     = i_ff + AW'(1);
                  state_in = S_POP_RD;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_size_in   = res_size_ff;
               rsp_total_in  = cnt_w[6:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      w_ff          <= w_in;
      cmd_ff        <= cmd_in;
      want_ff       <= want_in;
      carry_ff      <= carry_in;
      swap_ff       <= swap_in;
      have_ff       <= have_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_total_ff  <= rsp_total_in;
   end

endmodule

`default_nettype wire
